[src/assert_macros.svh]
// assertion macros shared by the matrix multiply engine modules
// expects i_clk (and i_rst_n for MME_ASSERT) in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check while out of reset
`define MME_ASSERT(lbl, prp, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prp)) else $error(msg);

// check on every edge, reset included
`define MME_ASSERT_ALWAYS(lbl, prp, msg) \
    lbl: assert property (@(posedge i_clk) (prp)) else $error(msg);

`endif

[src/mme_pkg.sv]
// shared constants, register indexes and controller/datapath structs
// no dependencies
package mme_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 35;
    localparam int IDX_OUT_W   = 3;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = CFG_IDX_W'(2);

    // controller -> datapath
    typedef struct packed {
        logic load_en;  // load phase: input open, indices held at zero
        logic issue;    // read one a/b pair and step k
        logic emit;     // move finished sum to output, step j/i
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic load_done;  // this transaction completes both loads
        logic k_last;     // current pair is the last of the dot product
        logic res_vld;    // dot product finished
        logic out_free;   // output register can take a result
        logic elem_last;  // current element is the last of the product
    } t_ctrl_sts;

endpackage

[src/mme_in_if.sv]
// input channel: element loads
// depends on mme_pkg
interface mme_in_if;
    import mme_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [ELEM_W-1:0] elem_value;

    modport source (output valid, req_type, elem_value, input ready);
    modport sink   (input valid, req_type, elem_value, output ready);
endinterface

[src/mme_out_if.sv]
// output channel: product elements
// depends on mme_pkg
interface mme_out_if;
    import mme_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [PROD_W-1:0] prod_value;
    logic [IDX_OUT_W-1:0]     prod_row;
    logic [IDX_OUT_W-1:0]     prod_col;
    logic                     last_elem;

    modport source (output valid, prod_value, prod_row, prod_col, last_elem, input ready);
    modport sink   (input valid, prod_value, prod_row, prod_col, last_elem, output ready);
endinterface

[src/mme_ctrl.sv]
// sequencing state machine: load, issue dot product, emit result
// depends on mme_pkg and assert_macros.svh
`include "assert_macros.svh"

module mme_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mme_pkg::t_ctrl_sts i_sts,
    output mme_pkg::t_ctrl_cmd o_cmd
);
    import mme_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_ISSUE = 3'b010,
        S_EMIT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd.load_en = 1'b0;
        o_cmd.issue   = 1'b0;
        o_cmd.emit    = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load_en = 1'b1;
                if (i_sts.load_done) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.res_vld && i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.elem_last ? S_LOAD : S_ISSUE;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `MME_ASSERT(a_load_to_issue, i_sts.load_done |=> o_cmd.issue, "no issue after load completed")
    `MME_ASSERT(a_last_to_load, (o_cmd.emit && i_sts.elem_last) |=> o_cmd.load_en, "no reload after final element")
    `MME_ASSERT(a_emit_needs_sum, o_cmd.emit |-> (i_sts.res_vld && !o_cmd.issue), "emit without finished sum")

endmodule

[src/mme_dp.sv]
// datapath: config registers, element stores, address walk, mac pipeline, output register
// depends on mme_pkg and assert_macros.svh
`include "assert_macros.svh"

module mme_dp #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_req_type,
    input  logic signed [mme_pkg::ELEM_W-1:0] i_elem_value,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic signed [mme_pkg::PROD_W-1:0] o_prod_value,
    output logic [mme_pkg::IDX_OUT_W-1:0]     o_prod_row,
    output logic [mme_pkg::IDX_OUT_W-1:0]     o_prod_col,
    output logic                              o_last_elem,
    input  mme_pkg::t_ctrl_cmd                i_cmd,
    output mme_pkg::t_ctrl_sts                o_sts
);
    import mme_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int PW    = 2 * DW;
    localparam int MW    = 2 * ELEM_W;
    localparam int ACC_W = PROD_W + 1;

    localparam logic signed [PROD_W-1:0] VAL_MAX = {1'b0, {(PROD_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] VAL_MIN = {1'b1, {(PROD_W-1){1'b0}}};

    function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [DW-1:0] r;
        if (v == '0) begin
            r = DW'(1);
        end else if (int'(v) > MAX_DIM) begin
            r = DW'(MAX_DIM);
        end else begin
            r = DW'(v);
        end
        return r;
    endfunction

    // configuration
    logic [CFG_W-1:0] r_rows_a;
    logic [CFG_W-1:0] r_inner_dim;
    logic [CFG_W-1:0] r_cols_b;
    logic             w_cfg_hit;

    // load side
    logic [CW-1:0] r_a_cnt;
    logic [CW-1:0] r_b_cnt;
    logic [CW-1:0] w_a_cnt_nx;
    logic [CW-1:0] w_b_cnt_nx;
    logic [DW-1:0] w_x;
    logic [DW-1:0] w_y;
    logic [DW-1:0] w_z;
    logic [PW-1:0] w_need_a;
    logic [PW-1:0] w_need_b;
    logic          w_fire;
    logic          w_a_wr;
    logic          w_b_wr;
    logic          w_load_done;

    // stores
    logic [ELEM_W-1:0] a_mem [DEPTH];
    logic [ELEM_W-1:0] b_mem [DEPTH];

    // address walk
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [IW-1:0] r_k;
    logic [AW-1:0] r_a_base;
    logic [AW-1:0] r_a_addr;
    logic [AW-1:0] r_b_addr;
    logic          w_i_last;
    logic          w_j_last;
    logic          w_k_last;

    // mac pipeline
    logic signed [ELEM_W-1:0] r_a_rd;
    logic signed [ELEM_W-1:0] r_b_rd;
    logic                     r_rd_vld;
    logic                     r_rd_last;
    logic signed [MW-1:0]     r_mul;
    logic                     r_mul_vld;
    logic                     r_mul_last;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_res_vld;
    logic signed [PROD_W-1:0] w_sat;

    // output register
    logic                     r_out_vld;
    logic signed [PROD_W-1:0] r_out_val;
    logic [IDX_OUT_W-1:0]     r_out_row;
    logic [IDX_OUT_W-1:0]     r_out_col;
    logic                     r_out_last;

    assign w_cfg_hit = i_cfg_we && ((i_cfg_idx == REG_ROWS_A) || (i_cfg_idx == REG_INNER_DIM)
                       || (i_cfg_idx == REG_COLS_B));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= CFG_RESET;
            r_inner_dim <= CFG_RESET;
            r_cols_b    <= CFG_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_ROWS_A) begin
                r_rows_a <= i_cfg_data;
            end
            if (i_cfg_idx == REG_INNER_DIM) begin
                r_inner_dim <= i_cfg_data;
            end
            if (i_cfg_idx == REG_COLS_B) begin
                r_cols_b <= i_cfg_data;
            end
        end
    end

    assign w_x      = eff_dim(r_rows_a);
    assign w_y      = eff_dim(r_inner_dim);
    assign w_z      = eff_dim(r_cols_b);
    assign w_need_a = PW'(w_x) * PW'(w_y);
    assign w_need_b = PW'(w_y) * PW'(w_z);

    // an element for an already full matrix is dropped
    assign w_fire      = i_in_valid && i_cmd.load_en;
    assign w_a_wr      = w_fire && !i_req_type && (PW'(r_a_cnt) < w_need_a);
    assign w_b_wr      = w_fire && i_req_type && (PW'(r_b_cnt) < w_need_b);
    assign w_a_cnt_nx  = r_a_cnt + CW'(w_a_wr);
    assign w_b_cnt_nx  = r_b_cnt + CW'(w_b_wr);
    assign w_load_done = (w_a_wr || w_b_wr) && (PW'(w_a_cnt_nx) >= w_need_a)
                         && (PW'(w_b_cnt_nx) >= w_need_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_cnt <= '0;
            r_b_cnt <= '0;
        end else if (w_cfg_hit || w_load_done) begin
            r_a_cnt <= '0;
            r_b_cnt <= '0;
        end else begin
            r_a_cnt <= w_a_cnt_nx;
            r_b_cnt <= w_b_cnt_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_wr) begin
            a_mem[r_a_cnt[AW-1:0]] <= i_elem_value;
        end
        if (i_cmd.issue) begin
            r_a_rd <= a_mem[r_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b_wr) begin
            b_mem[r_b_cnt[AW-1:0]] <= i_elem_value;
        end
        if (i_cmd.issue) begin
            r_b_rd <= b_mem[r_b_addr];
        end
    end

    assign w_i_last = (DW'(r_i) + DW'(1)) == w_x;
    assign w_j_last = (DW'(r_j) + DW'(1)) == w_z;
    assign w_k_last = (DW'(r_k) + DW'(1)) == w_y;

    // a walks along row i (stride 1), b walks down column j (stride z)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load_en) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_a_base <= '0;
            r_a_addr <= '0;
            r_b_addr <= '0;
        end else if (i_cmd.issue) begin
            r_k      <= r_k + IW'(1);
            r_a_addr <= r_a_addr + AW'(1);
            r_b_addr <= r_b_addr + AW'(w_z);
        end else if (i_cmd.emit) begin
            r_k <= '0;
            if (w_j_last) begin
                r_j      <= '0;
                r_i      <= r_i + IW'(1);
                r_a_base <= r_a_base + AW'(w_y);
                r_a_addr <= r_a_base + AW'(w_y);
                r_b_addr <= '0;
            end else begin
                r_j      <= r_j + IW'(1);
                r_a_addr <= r_a_base;
                r_b_addr <= AW'(r_j) + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_rd_last  <= 1'b0;
            r_mul_vld  <= 1'b0;
            r_mul_last <= 1'b0;
            r_res_vld  <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_rd_vld   <= i_cmd.issue;
            r_rd_last  <= i_cmd.issue && w_k_last;
            r_mul_vld  <= r_rd_vld;
            r_mul_last <= r_rd_last;
            if (i_cmd.emit) begin
                r_res_vld <= 1'b0;
                r_acc     <= '0;
            end else if (r_mul_vld) begin
                r_res_vld <= r_mul_last;
                r_acc     <= r_acc + ACC_W'(r_mul);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul <= r_a_rd * r_b_rd;
    end

    assign w_sat = (r_acc[ACC_W-1] != r_acc[ACC_W-2]) ? (r_acc[ACC_W-1] ? VAL_MIN : VAL_MAX)
                                                      : r_acc[PROD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_val  <= w_sat;
            r_out_row  <= IDX_OUT_W'(r_i);
            r_out_col  <= IDX_OUT_W'(r_j);
            r_out_last <= w_i_last && w_j_last;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_prod_value = r_out_val;
    assign o_prod_row   = r_out_row;
    assign o_prod_col   = r_out_col;
    assign o_last_elem  = r_out_last;

    assign o_sts.load_done = w_load_done;
    assign o_sts.k_last    = w_k_last;
    assign o_sts.res_vld   = r_res_vld;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;
    assign o_sts.elem_last = w_i_last && w_j_last;

    `MME_ASSERT(a_pipe_empty, r_res_vld |-> (!r_rd_vld && !r_mul_vld), "sum done with pipe busy")
    `MME_ASSERT(a_a_cnt_bound, PW'(r_a_cnt) <= w_need_a, "a load count past its size")
    `MME_ASSERT(a_b_cnt_bound, PW'(r_b_cnt) <= w_need_b, "b load count past its size")

endmodule

[src/matrix_multiply_engine.sv]
// loading: one element transaction per cycle while the load phase is open
// compute: rows_a*cols_b results, each through a single mac
//   (one a/b read pair per cycle, then read, multiply and accumulate registers)
// first result follows the transaction that completes both loads, once its sum is done
// no input taken during compute
// reset (sync, active low): dims back to 8, load counts zero, stores keep contents
//
// top level of the fixed-point matrix multiply engine
// depends on mme_pkg, mme_in_if, mme_out_if, mme_ctrl, mme_dp
module matrix_multiply_engine #(
    parameter int MAX_DIM = mme_pkg::MAX_DIM_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes: 0 rows_a, 1 inner_dim, 2 cols_b
    input  logic                          i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]     i_cfg_data,
    // element loads, a first then b, row-major
    mme_in_if.sink                        i_in_ch,
    // product elements, row-major
    mme_out_if.source                     o_out_ch
);
    import mme_pkg::*;

    t_ctrl_cmd w_cmd;
    t_ctrl_sts w_sts;

    // input is open only in the load phase
    assign i_in_ch.ready = w_cmd.load_en;

    // controller: load, then issue k pairs -> emit, repeated per product element
    mme_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // datapath: stores, address walk, mac and output register
    mme_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_ch.valid),
        .i_req_type   (i_in_ch.req_type),
        .i_elem_value (i_in_ch.elem_value),
        .i_out_ready  (o_out_ch.ready),
        .o_out_valid  (o_out_ch.valid),
        .o_prod_value (o_out_ch.prod_value),
        .o_prod_row   (o_out_ch.prod_row),
        .o_prod_col   (o_out_ch.prod_col),
        .o_last_elem  (o_out_ch.last_elem),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts)
    );

endmodule
